[src/epd_pkg.sv]
// Shared types and constants for the encoder PD position drive.
// Depends on nothing; used by encoder_pd_position_drive and epd_serial_mul.
package epd_pkg;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 60;

  localparam logic [1:0] CMD_EDGE   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_TARGET = 2'd2;

  localparam logic [2:0] CFG_RAD_PER_COUNT = 3'd0;
  localparam logic [2:0] CFG_WINDER_RADIUS = 3'd1;
  localparam logic [2:0] CFG_PROP_GAIN     = 3'd2;
  localparam logic [2:0] CFG_DERIV_GAIN    = 3'd3;
  localparam logic [2:0] CFG_UPPER_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_LOWER_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_DEADBAND      = 3'd6;

  localparam logic [17:0]        RST_RAD_PER_COUNT = 18'd68629;
  localparam logic [11:0]        RST_WINDER_RADIUS = 12'd1152;
  localparam logic [15:0]        RST_PROP_GAIN     = 16'd1000;
  localparam logic [15:0]        RST_DERIV_GAIN    = 16'd0;
  localparam logic signed [15:0] RST_UPPER_LIMIT   = 16'sd5632;
  localparam logic signed [15:0] RST_LOWER_LIMIT   = -16'sd3072;
  localparam logic [7:0]         RST_DEADBAND      = 8'd25;

  typedef struct packed {
    logic [1:0]         command;
    logic               pin_a;
    logic               pin_b;
    logic signed [15:0] target;
  } item_t;

  typedef struct packed {
    logic [7:0]         drive_level;
    logic               direction;
    logic signed [23:0] encoder_count;
    logic signed [47:0] angle;
    logic signed [39:0] position;
  } result_t;

  typedef struct packed {
    logic start;
    logic accumulate;
  } mul_ctl_t;

endpackage

[src/encoder_pd_position_drive.sv]
// Encoder PD position drive: one transaction at a time, result held in an output register.
// Edge, set-target and unused commands go from IDLE straight to DONE; the result register
// loads from DONE once the output is not stalled. Control tick: serial multiplies for angle,
// position and proportional term, then the derivative term accumulated, then FINISH, DONE.
// The next transaction is taken the cycle after the result register loads.
// Sync reset loads register defaults and clears count, angle, position, setpoint, error, drive.
module encoder_pd_position_drive #(
  parameter int COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  epd_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_stall,
  output epd_pkg::result_t   result,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  typedef enum logic [3:0] {
    IDLE, M_ANGLE, W_ANGLE, M_POS, W_POS, M_PROP, W_PROP,
    M_DERIV, W_DERIV, FINISH, DONE
  } state_t;

  state_t state;

  logic [17:0]        rad_per_count;
  logic [11:0]        winder_radius;
  logic [15:0]        prop_gain;
  logic [15:0]        deriv_gain;
  logic signed [15:0] upper_limit;
  logic signed [15:0] lower_limit;
  logic [7:0]         deadband;

  logic signed [47:0] angle_reg;
  logic signed [39:0] position_reg;
  logic signed [15:0] setpoint;
  logic signed [40:0] previous_error;
  logic signed [40:0] error_reg;
  logic [7:0]         drive_reg;
  logic               direction_reg;

  logic                                     accept;
  logic signed [COUNT_BITS-1:0]             count;
  logic signed [47:0]                       count_ext;
  epd_pkg::mul_ctl_t                        mul_ctl;
  logic signed [epd_pkg::MUL_A_W-1:0]       mul_a;
  logic        [epd_pkg::MUL_B_W-1:0]       mul_b;
  logic                                     mul_busy;
  logic signed [epd_pkg::MUL_P_W-1:0]       prod;
  logic signed [47:0]                       angle_sat;
  logic signed [39:0]                       pos_sat;
  logic signed [40:0]                       error_next;
  logic signed [41:0]                       diff;
  logic [epd_pkg::MUL_P_W-1:0]              mag;
  logic [7:0]                               level;
  logic                                     outside;
  logic signed [15:0]                       target_clamped;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != IDLE);

  epd_counter #(.COUNT_BITS(COUNT_BITS)) u_counter (
    .clk   (clk),
    .rst   (rst),
    .step  (accept && item.command == epd_pkg::CMD_EDGE),
    .up    (item.pin_a != item.pin_b),
    .count (count)
  );

  assign count_ext = {{(48-COUNT_BITS){count[COUNT_BITS-1]}}, count};

  always_comb begin
    if (item.target < lower_limit) begin
      target_clamped = lower_limit;
    end else if (item.target > upper_limit) begin
      target_clamped = upper_limit;
    end else begin
      target_clamped = item.target;
    end
  end

  always_comb begin
    if ((&prod[59:47]) || !(|prod[59:47])) begin
      angle_sat = prod[47:0];
    end else begin
      angle_sat = prod[59] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    if ((&prod[59:55]) || !(|prod[59:55])) begin
      pos_sat = prod[55:16];
    end else begin
      pos_sat = prod[59] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end
  end

  assign error_next = $signed({{25{setpoint[15]}}, setpoint}) - $signed({position_reg[39], position_reg});
  assign diff = $signed({error_reg[40], error_reg}) - $signed({previous_error[40], previous_error});
  assign mag   = prod[59] ? (~prod + 60'd1) : prod;
  assign level = (|mag[59:16]) ? 8'hFF : mag[15:8];
  assign outside = (position_reg > upper_limit) || (position_reg < lower_limit);

  always_comb begin
    mul_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      M_ANGLE: begin
        mul_ctl.start = 1'b1;
        mul_a = count_ext;
        mul_b = rad_per_count;
      end
      M_POS: begin
        mul_ctl.start = 1'b1;
        mul_a = angle_reg;
        mul_b = {6'd0, winder_radius};
      end
      M_PROP: begin
        mul_ctl.start = 1'b1;
        mul_a = {{7{error_next[40]}}, error_next};
        mul_b = {2'd0, prop_gain};
      end
      M_DERIV: begin
        mul_ctl.start = 1'b1;
        mul_ctl.accumulate = 1'b1;
        mul_a = {{6{diff[41]}}, diff};
        mul_b = {2'd0, deriv_gain};
      end
      default: begin
      end
    endcase
  end

  epd_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mul_ctl),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_per_count <= epd_pkg::RST_RAD_PER_COUNT;
      winder_radius <= epd_pkg::RST_WINDER_RADIUS;
      prop_gain     <= epd_pkg::RST_PROP_GAIN;
      deriv_gain    <= epd_pkg::RST_DERIV_GAIN;
      upper_limit   <= epd_pkg::RST_UPPER_LIMIT;
      lower_limit   <= epd_pkg::RST_LOWER_LIMIT;
      deadband      <= epd_pkg::RST_DEADBAND;
    end else if (cfg_we) begin
      case (cfg_index)
        epd_pkg::CFG_RAD_PER_COUNT: rad_per_count <= cfg_data;
        epd_pkg::CFG_WINDER_RADIUS: winder_radius <= cfg_data[11:0];
        epd_pkg::CFG_PROP_GAIN:     prop_gain     <= cfg_data[15:0];
        epd_pkg::CFG_DERIV_GAIN:    deriv_gain    <= cfg_data[15:0];
        epd_pkg::CFG_UPPER_LIMIT:   upper_limit   <= cfg_data[15:0];
        epd_pkg::CFG_LOWER_LIMIT:   lower_limit   <= cfg_data[15:0];
        epd_pkg::CFG_DEADBAND:      deadband      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      angle_reg      <= '0;
      position_reg   <= '0;
      setpoint       <= '0;
      previous_error <= '0;
      error_reg      <= '0;
      drive_reg      <= '0;
      direction_reg  <= 1'b0;
      result_valid   <= 1'b0;
      result         <= '0;
    end else begin
      if (state == DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item_valid) begin
            if (item.command == epd_pkg::CMD_TICK) begin
              state <= M_ANGLE;
            end else begin
              if (item.command == epd_pkg::CMD_TARGET) setpoint <= target_clamped;
              state <= DONE;
            end
          end
        end
        M_ANGLE: state <= W_ANGLE;
        W_ANGLE: begin
          if (!mul_busy) begin
            angle_reg <= angle_sat;
            state <= M_POS;
          end
        end
        M_POS: state <= W_POS;
        W_POS: begin
          if (!mul_busy) begin
            position_reg <= pos_sat;
            state <= M_PROP;
          end
        end
        M_PROP: begin
          error_reg <= error_next;
          state <= W_PROP;
        end
        W_PROP: begin
          if (!mul_busy) state <= M_DERIV;
        end
        M_DERIV: state <= W_DERIV;
        W_DERIV: begin
          if (!mul_busy) state <= FINISH;
        end
        FINISH: begin
          if (outside) begin
            drive_reg <= '0;
          end else begin
            drive_reg <= (level > deadband) ? level : 8'd0;
            direction_reg <= prod[59];
          end
          previous_error <= error_reg;
          state <= DONE;
        end
        DONE: begin
          if (!result_valid || !result_stall) begin
            result.drive_level   <= drive_reg;
            result.direction     <= direction_reg;
            result.encoder_count <= count_ext[23:0];
            result.angle         <= angle_reg;
            result.position      <= position_reg;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> (state == W_ANGLE || state == W_POS || state == W_PROP || state == W_DERIV))
    else $error("multiplier busy outside a wait state");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == M_ANGLE || state == DONE))
    else $error("accepted transaction did not start");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == DONE && (!result_valid || !result_stall) |=> result_valid && state == IDLE)
    else $error("finished transaction not delivered");
  a_outside_hold: assert property (@(posedge clk) disable iff (rst)
    state == FINISH && outside |=> drive_reg == 8'd0 && $stable(direction_reg))
    else $error("drive not cut outside limits");

endmodule

[src/epd_serial_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle, optional accumulation. Uses epd_pkg.
module epd_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  epd_pkg::mul_ctl_t                    ctl,
  input  logic signed [epd_pkg::MUL_A_W-1:0]   a,
  input  logic        [epd_pkg::MUL_B_W-1:0]   b,
  output logic                                 busy,
  output logic signed [epd_pkg::MUL_P_W-1:0]   product
);

  logic [epd_pkg::MUL_P_W-1:0] areg;
  logic [epd_pkg::MUL_B_W-1:0] breg;
  logic [epd_pkg::MUL_P_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= |breg[epd_pkg::MUL_B_W-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      areg <= {{(epd_pkg::MUL_P_W - epd_pkg::MUL_A_W){a[epd_pkg::MUL_A_W-1]}}, a};
      breg <= b;
      if (!ctl.accumulate) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (breg[0]) begin
        acc <= acc + areg;
      end
      areg <= {areg[epd_pkg::MUL_P_W-2:0], 1'b0};
      breg <= {1'b0, breg[epd_pkg::MUL_B_W-1:1]};
    end
  end

  assign product = $signed(acc);

  a_start_busy: assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("multiplier did not go busy after start");
  a_stop_empty: assert property (@(posedge clk) disable iff (rst)
    busy && !ctl.start && breg[epd_pkg::MUL_B_W-1:1] == '0 |=> !busy)
    else $error("multiplier ran past its last bit");

endmodule

[src/epd_counter.sv]
// Saturating signed up/down counter for quadrature encoder edges.
// Standalone; no package dependencies.
module epd_counter #(
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         up,
  output logic signed [COUNT_BITS-1:0] count
);

  localparam logic [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      if (up) begin
        if (count != CMAX) count <= count + ONE;
      end else begin
        if (count != CMIN) count <= count - ONE;
      end
    end
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for encoder_pd_position_drive: directed and random transactions
// against an in-line model of the count, angle, position and PD drive math.
// Depends on epd_pkg and the encoder_pd_position_drive RTL under src.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W = 24;
  localparam longint COUNT_MAX = (longint'(1) << (COUNT_W - 1)) - 1;
  localparam longint COUNT_MIN = -COUNT_MAX - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PRINT_CAP = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  epd_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  epd_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = epd_pkg::CFG_RAD_PER_COUNT;
  logic [17:0] cfg_data = '0;

  always #10ns clk = ~clk;

  encoder_pd_position_drive #(.COUNT_BITS(COUNT_W)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // drive model: settings and state
  logic [17:0] rad_per_count = epd_pkg::RST_RAD_PER_COUNT;
  logic [11:0] winder_radius = epd_pkg::RST_WINDER_RADIUS;
  logic [15:0] kp = epd_pkg::RST_PROP_GAIN;
  logic [15:0] kd = epd_pkg::RST_DERIV_GAIN;
  shortint upper_lim = epd_pkg::RST_UPPER_LIMIT;
  shortint lower_lim = epd_pkg::RST_LOWER_LIMIT;
  logic [7:0] deadband = epd_pkg::RST_DEADBAND;

  longint count_q = 0;
  longint angle_q = 0;
  longint pos_q = 0;
  shortint setpoint_q = 0;
  longint prev_err_q = 0;
  logic [7:0] drive_q = '0;
  logic dir_q = 1'b0;

  epd_pkg::result_t expected_status[$];
  int mismatches = 0;
  int cycle_count = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  epd_pkg::result_t want;

  function automatic epd_pkg::result_t next_status(epd_pkg::item_t it);
    longint err, ctl, mag;
    shortint t;
    logic [7:0] lvl;
    epd_pkg::result_t r;
    case (it.command)
      epd_pkg::CMD_EDGE: begin
        if (it.pin_a != it.pin_b) begin
          if (count_q < COUNT_MAX) count_q++;
        end else begin
          if (count_q > COUNT_MIN) count_q--;
        end
      end
      epd_pkg::CMD_TICK: begin
        angle_q = count_q * longint'(rad_per_count);
        pos_q = (angle_q * longint'(winder_radius)) >>> 16;
        err = longint'(setpoint_q) - pos_q;
        ctl = longint'(kp) * err + longint'(kd) * (err - prev_err_q);
        if (pos_q > upper_lim || pos_q < lower_lim) begin
          drive_q = '0;
        end else begin
          mag = (ctl < 0) ? -ctl : ctl;
          mag = mag >> 8;
          lvl = (mag > 255) ? 8'd255 : mag[7:0];
          drive_q = (lvl > deadband) ? lvl : 8'd0;
          dir_q = (ctl < 0);
        end
        prev_err_q = err;
      end
      epd_pkg::CMD_TARGET: begin
        t = it.target;
        if (t < lower_lim) t = lower_lim;
        else if (t > upper_lim) t = upper_lim;
        setpoint_q = t;
      end
      default: ;
    endcase
    r.drive_level = drive_q;
    r.direction = dir_q;
    r.encoder_count = count_q[23:0];
    r.angle = angle_q[47:0];
    r.position = pos_q[39:0];
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic epd_pkg::item_t mk(logic [1:0] c, logic a, logic b,
                                        logic signed [15:0] t);
    epd_pkg::item_t it;
    it.command = c;
    it.pin_a = a;
    it.pin_b = b;
    it.target = t;
    return it;
  endfunction

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
  endtask

  task automatic send_item(input epd_pkg::item_t it, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    expected_status.push_back(next_status(it));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic configure(input logic [17:0] rpc, input logic [11:0] wr,
                           input logic [15:0] p, input logic [15:0] d,
                           input shortint up, input shortint lo, input logic [7:0] db);
    write_reg(epd_pkg::CFG_RAD_PER_COUNT, rpc);
    write_reg(epd_pkg::CFG_WINDER_RADIUS, {6'd0, wr});
    write_reg(epd_pkg::CFG_PROP_GAIN, {2'b00, p});
    write_reg(epd_pkg::CFG_DERIV_GAIN, {2'b00, d});
    write_reg(epd_pkg::CFG_UPPER_LIMIT, {2'b00, up});
    write_reg(epd_pkg::CFG_LOWER_LIMIT, {2'b00, lo});
    write_reg(epd_pkg::CFG_DEADBAND, {10'd0, db});
    cfg_we <= 1'b0;
    rad_per_count = rpc;
    winder_radius = wr;
    kp = p;
    kd = d;
    upper_lim = up;
    lower_lim = lo;
    deadband = db;
  endtask

  // count wanders toward a moving goal so ticks land inside and outside the limits
  task automatic run_random(input int n, input int span);
    epd_pkg::item_t it;
    int goal, r, t;
    bit up;
    goal = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) goal = int'($urandom_range(0, 2 * span)) - span;
      it.pin_a = 1'($urandom);
      it.pin_b = 1'($urandom);
      it.target = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        it.command = epd_pkg::CMD_EDGE;
        if ($urandom_range(0, 4) != 0) begin
          up = (count_q < goal);
          it.pin_b = up ? ~it.pin_a : it.pin_a;
        end
      end else if (r < 85) begin
        it.command = epd_pkg::CMD_TICK;
      end else if (r < 97) begin
        it.command = epd_pkg::CMD_TARGET;
        if ($urandom_range(0, 1) && lower_lim <= upper_lim) begin
          t = int'(lower_lim) + int'($urandom_range(0, int'(upper_lim) - int'(lower_lim)));
          it.target = 16'(t);
        end
      end else begin
        it.command = CMD_UNUSED;
      end
      send_item(it, tx_idle_on ? idle_len() : 0);
    end
  endtask

  task automatic test_directed_defaults();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(mk(epd_pkg::CMD_TICK, 1'b0, 1'b0, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_TARGET, 1'b0, 1'b0, 16'sh7fff), idle_len());
    send_item(mk(epd_pkg::CMD_TARGET, 1'b1, 1'b1, -16'sh8000), idle_len());
    send_item(mk(epd_pkg::CMD_TARGET, 1'b0, 1'b1, 16'sd1000), idle_len());
    send_item(mk(epd_pkg::CMD_EDGE, 1'b0, 1'b1, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_EDGE, 1'b1, 1'b0, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_EDGE, 1'b0, 1'b0, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_EDGE, 1'b1, 1'b1, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_EDGE, 1'b0, 1'b1, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_TICK, 1'b1, 1'b0, 16'sh7fff), idle_len());
    // small error lands inside the deadband
    send_item(mk(epd_pkg::CMD_TARGET, 1'b0, 1'b0, 16'sd1210), idle_len());
    send_item(mk(epd_pkg::CMD_TICK, 1'b0, 1'b0, 16'sd0), idle_len());
    send_item(mk(epd_pkg::CMD_TARGET, 1'b0, 1'b0, 16'sd1236), idle_len());
    send_item(mk(epd_pkg::CMD_TICK, 1'b0, 1'b0, 16'sd0), idle_len());
    repeat (4) send_item(mk(epd_pkg::CMD_EDGE, 1'b1, 1'b0, 16'sd0), idle_len());
    // past the upper limit: drive off, direction held
    send_item(mk(epd_pkg::CMD_TICK, 1'b1, 1'b1, -16'sd1), idle_len());
    send_item(mk(CMD_UNUSED, 1'b1, 1'b1, -16'sd1), idle_len());
    wait_idle();
  endtask

  task automatic test_register_extremes();
    configure('0, '0, '0, '0, 16'sd0, 16'sd0, '0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_random(150, 4);
    wait_idle();
    configure('1, '1, '1, '1, 16'sh7fff, -16'sh8000, '1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    run_random(150, 4);
    wait_idle();
  endtask

  task automatic test_crossed_limits();
    configure(18'd2000, 12'd1500, 16'd40, 16'd300, -16'sd1000, 16'sd1000, 8'd10);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(150, 40);
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [17:0] rpc;
    shortint up, lo;
    bit small_step;
    for (int k = 0; k < 8; k++) begin
      small_step = ($urandom_range(0, 3) != 0);
      rpc = small_step ? 18'($urandom_range(0, 3000)) : 18'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        up = shortint'($urandom_range(0, 12000));
        lo = -shortint'($urandom_range(0, 12000));
      end else begin
        up = shortint'($urandom);
        lo = shortint'($urandom);
      end
      configure(rpc, 12'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)),
                ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)),
                up, lo,
                ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
      tx_idle_on = (k % 4 != 1);
      rx_idle_on = (k % 3 != 0);
      run_random(150, small_step ? 80 : 4);
      wait_idle();
    end
  endtask

  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_req = 1'b1;
    run_random(15, 6);
    wait_idle();
  endtask

  task automatic test_defaults_restored();
    configure(epd_pkg::RST_RAD_PER_COUNT, epd_pkg::RST_WINDER_RADIUS,
              epd_pkg::RST_PROP_GAIN, epd_pkg::RST_DERIV_GAIN,
              epd_pkg::RST_UPPER_LIMIT, epd_pkg::RST_LOWER_LIMIT, epd_pkg::RST_DEADBAND);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(200, 6);
    wait_idle();
  endtask

  // result side: check each transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_status.size() == 0) begin
        report("result with nothing expected", '0, 64'(result));
      end else begin
        want = expected_status.pop_front();
        if (result.drive_level !== want.drive_level)
          report("drive_level", 64'(want.drive_level), 64'(result.drive_level));
        if (result.direction !== want.direction)
          report("direction", 64'(want.direction), 64'(result.direction));
        if (result.encoder_count !== want.encoder_count)
          report("encoder_count", 64'(want.encoder_count), 64'(result.encoder_count));
        if (result.angle !== want.angle)
          report("angle", 64'(want.angle), 64'(result.angle));
        if (result.position !== want.position)
          report("position", 64'(want.position), 64'(result.position));
      end
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      if (rx_idle_on) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_register_extremes();
    test_crossed_limits();
    test_random_settings();
    test_back_pressure();
    test_defaults_restored();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
